>>> rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared constants and types for the binary max-heap priority queue: sizes,
// command and status codes, and the control/status bundles between the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int DATA_W   = 32;

  // heap positions run 1..CAPACITY, the count runs 0..CAPACITY
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = CNT_W;
  localparam int ADDR_W = $clog2(CAPACITY);

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_PEEK    = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       up_rd;
    logic       up_step;
    logic       root_take;
    logic       dn_rd;
    logic       dn_step;
    logic       place;
    logic       out_ld;
    logic [1:0] status;
  } bmhq_ctl_t;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic [1:0] cmd;
    logic       count_zero;
    logic       count_full;
    logic       at_root;
    logic       up_gt;
    logic       has_child;
    logic       dn_gt;
  } bmhq_sts_t;

endpackage

>>> rtl/bmhq_cmd_if.sv
// ----------------------------------------------------------------------------
// bmhq_cmd_if
// Command channel: valid/ready handshake with command code and value.
// ----------------------------------------------------------------------------
interface bmhq_cmd_if import bmhq_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [DATA_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);

endinterface

>>> rtl/bmhq_res_if.sv
// ----------------------------------------------------------------------------
// bmhq_res_if
// Result channel: valid/ready handshake with status, data and entry count.
// ----------------------------------------------------------------------------
interface bmhq_res_if import bmhq_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [DATA_W-1:0] data;
  logic [CNT_W-1:0]  item_count;

  modport source (output valid, output status, output data, output item_count,
                  input ready);
  modport sink   (input valid, input status, input data, input item_count,
                  output ready);

endinterface

>>> rtl/bmhq_datapath.sv
// ----------------------------------------------------------------------------
// bmhq_datapath
// Heap storage (one write port, two registered read ports), entry count,
// sift position and carried value, comparators and the result register.
// ----------------------------------------------------------------------------
module bmhq_datapath import bmhq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        in_command_i,
  input  logic [DATA_W-1:0] in_value_i,
  input  bmhq_ctl_t         ctl_i,
  output bmhq_sts_t         sts_o,
  output logic [1:0]        res_status_o,
  output logic [DATA_W-1:0] res_data_o,
  output logic [CNT_W-1:0]  res_count_o
);

  logic signed [DATA_W-1:0] heap_mem [CAPACITY];

  logic [CNT_W-1:0]         count_q, count_d;
  logic [POS_W-1:0]         pos_q;
  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] data_q;
  logic [1:0]               cmd_q;
  logic signed [DATA_W-1:0] rd_a_q, rd_b_q;
  logic [1:0]               res_status_q;
  logic [DATA_W-1:0]        res_data_q;
  logic [CNT_W-1:0]         res_count_q;

  logic [POS_W:0]           left_pos, right_pos, count_ext;
  logic [POS_W-1:0]         parent_pos, pick_pos;
  logic                     right_ok, take_right, up_gt, dn_gt, has_child;
  logic signed [DATA_W-1:0] pick_val, wdata;
  logic                     we;
  logic [ADDR_W-1:0]        waddr, raddr_a, raddr_b;
  logic                     count_full, do_insert;

  // heap position to memory index
  function automatic logic [ADDR_W-1:0] pos2addr(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] t;
    t = p - POS_W'(1);
    return t[ADDR_W-1:0];
  endfunction

  assign left_pos   = {pos_q, 1'b0};
  assign right_pos  = {pos_q, 1'b1};
  assign count_ext  = {1'b0, count_q};
  assign parent_pos = pos_q >> 1;
  assign has_child  = left_pos <= count_ext;
  assign right_ok   = right_pos <= count_ext;

  // left child wins a tie
  assign take_right = right_ok && (rd_b_q > rd_a_q);
  assign pick_val   = take_right ? rd_b_q : rd_a_q;
  assign pick_pos   = take_right ? right_pos[POS_W-1:0] : left_pos[POS_W-1:0];
  assign up_gt      = val_q > rd_a_q;
  assign dn_gt      = pick_val > val_q;

  assign count_full = count_q == CNT_W'(CAPACITY);
  assign do_insert  = ctl_i.accept && (in_command_i == CMD_INSERT) && !count_full;

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl_i.root_take && (cmd_q == CMD_EXTRACT)) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // write port: the hole at pos takes either the moved neighbor or the value
  always_comb begin
    we    = ctl_i.place || ctl_i.up_step || ctl_i.dn_step;
    waddr = pos2addr(pos_q);
    wdata = val_q;
    if (ctl_i.up_step && up_gt) begin
      wdata = rd_a_q;
    end else if (ctl_i.dn_step && dn_gt) begin
      wdata = pick_val;
    end
  end

  // idle cycles read the root and the last entry for the next command
  always_comb begin
    if (ctl_i.up_rd) begin
      raddr_a = pos2addr(parent_pos);
      raddr_b = pos2addr(right_pos[POS_W-1:0]);
    end else if (ctl_i.dn_rd) begin
      raddr_a = pos2addr(left_pos[POS_W-1:0]);
      raddr_b = pos2addr(right_pos[POS_W-1:0]);
    end else begin
      raddr_a = pos2addr(POS_W'(1));
      raddr_b = pos2addr(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rd_a_q <= heap_mem[raddr_a];
    rd_b_q <= heap_mem[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q  <= in_command_i;
      data_q <= '0;
      if (do_insert) begin
        pos_q <= count_q + POS_W'(1);
        val_q <= in_value_i;
      end
    end
    if (ctl_i.up_step && up_gt) begin
      pos_q <= parent_pos;
    end
    if (ctl_i.root_take) begin
      data_q <= rd_a_q;
      val_q  <= rd_b_q;
      pos_q  <= POS_W'(1);
    end
    if (ctl_i.dn_step && dn_gt) begin
      pos_q <= pick_pos;
    end
    if (ctl_i.out_ld) begin
      res_status_q <= ctl_i.status;
      res_data_q   <= data_q;
      res_count_q  <= count_q;
    end
  end

  assign sts_o.in_cmd     = in_command_i;
  assign sts_o.cmd        = cmd_q;
  assign sts_o.count_zero = count_q == '0;
  assign sts_o.count_full = count_full;
  assign sts_o.at_root    = pos_q == POS_W'(1);
  assign sts_o.up_gt      = up_gt;
  assign sts_o.has_child  = has_child;
  assign sts_o.dn_gt      = dn_gt;

  assign res_status_o = res_status_q;
  assign res_data_o   = res_data_q;
  assign res_count_o  = res_count_q;

endmodule

>>> rtl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for the heap: takes a command, walks the sift loop one level per
// check/compare state pair, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bmhq_ctrl import bmhq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  bmhq_sts_t sts_i,
  output bmhq_ctl_t ctl_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_CHK = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_ROOT   = 3'd3;
  localparam logic [2:0] S_DN_CHK = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] status_q, status_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    ctl_o       = '0;
    state_d     = state_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          status_d     = ST_OK;
          case (sts_i.in_cmd)
            CMD_INSERT: begin
              if (sts_i.count_full) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                state_d = S_UP_CHK;
              end
            end
            CMD_EXTRACT, CMD_PEEK: begin
              if (sts_i.count_zero) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                state_d = S_ROOT;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_UP_CHK: begin
        if (sts_i.at_root) begin
          ctl_o.place = 1'b1;
          state_d     = S_DONE;
        end else begin
          ctl_o.up_rd = 1'b1;
          state_d     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ctl_o.up_step = 1'b1;
        state_d       = sts_i.up_gt ? S_UP_CHK : S_DONE;
      end
      S_ROOT: begin
        ctl_o.root_take = 1'b1;
        state_d         = (sts_i.cmd == CMD_EXTRACT) ? S_DN_CHK : S_DONE;
      end
      S_DN_CHK: begin
        if (sts_i.has_child) begin
          ctl_o.dn_rd = 1'b1;
          state_d     = S_DN_CMP;
        end else begin
          ctl_o.place = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_DN_CMP: begin
        ctl_o.dn_step = 1'b1;
        state_d       = sts_i.dn_gt ? S_DN_CHK : S_DONE;
      end
      S_DONE: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    ctl_o.status = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Priority queue of signed values kept as a binary max-heap in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one command per transfer: insert (with value), extract
//   maximum or peek maximum. res_o returns exactly one result per command:
//   status (ok, empty, full), data (the maximum for extract/peek, else zero)
//   and the entry count after the command.
//   One command is in flight at a time; cmd_i.ready is high while the block
//   waits for a command. Per heap level the sift loop first reads the RAM
//   (both children at once on the way down), then compares and writes back.
//   An insert lets the new value climb toward the root; an extract lets the
//   moved entry sink from the root.
//   The result sits in an output register; a stalled receiver holds it there,
//   the next command is still taken and worked on, and its result waits until
//   the register is emptied.
//   Reset empties the heap at once (count to zero); RAM contents are not
//   cleared, as only positions up to the count are ever used.
// ----------------------------------------------------------------------------
module binary_max_heap_queue import bmhq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bmhq_cmd_if.sink          cmd_i,
  bmhq_res_if.source        res_o
);

  bmhq_ctl_t ctl;
  bmhq_sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  bmhq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_command_i (cmd_i.command),
    .in_value_i   (cmd_i.value),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .res_status_o (res_o.status),
    .res_data_o   (res_o.data),
    .res_count_o  (res_o.item_count)
  );

`ifndef SYNTHESIS
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status == ST_FULL)) |->
      (res_o.item_count == CNT_W'(CAPACITY)))
    else $error("full result with count below capacity");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status == ST_EMPTY)) |->
      ((res_o.item_count == '0) && (res_o.data == '0)))
    else $error("empty result with nonzero count or data");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.item_count <= CNT_W'(CAPACITY)))
    else $error("entry count above capacity");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("second command taken while one is in flight");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary max-heap priority queue. A queue of
// commands (directed corner cases, random mixes, a fill to capacity and a
// long drain) feeds a bursty driver; a monitor predicts each accepted
// command with a heap of its own and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import bmhq_pkg::*;

  typedef struct {
    logic [1:0]        command;
    logic [DATA_W-1:0] value;
    bit                hold;     // wait for all results before this transfer
  } heap_cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  item_count;
  } heap_result_t;

  logic clk_i;
  logic rst_ni;

  bmhq_cmd_if cmd_if ();
  bmhq_res_if res_if ();

  binary_max_heap_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  heap_cmd_t    cmd_queue[$];
  heap_result_t expected_results[$];

  // predicted heap contents, one-based
  logic signed [DATA_W-1:0] heap_mem [1:CAPACITY];
  int unsigned              heap_len;

  int unsigned sent_cnt;
  int unsigned result_cnt;
  int unsigned gen_count;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned mode_left;
  int unsigned stall_mode;
  bit          failed;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_NOP;
    cmd_if.value   = '0;
    res_if.ready   = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic heap_result_t heap_predict(logic [1:0] cmd, logic [DATA_W-1:0] val);
    heap_result_t             res;
    int unsigned              pos;
    int unsigned              child;
    logic signed [DATA_W-1:0] tmp;
    bit                       settled;
    res.status = ST_OK;
    res.data   = '0;
    if (cmd == CMD_INSERT) begin
      if (heap_len >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        heap_len           = heap_len + 1;
        heap_mem[heap_len] = $signed(val);
        pos                = heap_len;
        while (pos > 1 && heap_mem[pos] > heap_mem[pos / 2]) begin
          tmp               = heap_mem[pos];
          heap_mem[pos]     = heap_mem[pos / 2];
          heap_mem[pos / 2] = tmp;
          pos               = pos / 2;
        end
      end
    end else if (cmd == CMD_EXTRACT || cmd == CMD_PEEK) begin
      if (heap_len == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.data = heap_mem[1];
        if (cmd == CMD_EXTRACT) begin
          heap_mem[1] = heap_mem[heap_len];
          heap_len    = heap_len - 1;
          pos         = 1;
          settled     = 1'b0;
          while (!settled && 2 * pos <= heap_len) begin
            child = 2 * pos;
            // left child wins a tie
            if (child + 1 <= heap_len && heap_mem[child + 1] > heap_mem[child])
              child = child + 1;
            if (heap_mem[child] > heap_mem[pos]) begin
              tmp             = heap_mem[pos];
              heap_mem[pos]   = heap_mem[child];
              heap_mem[child] = tmp;
              pos             = child;
            end else begin
              settled = 1'b1;
            end
          end
        end
      end
    end
    res.item_count = heap_len[CNT_W-1:0];
    return res;
  endfunction

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    heap_cmd_t nxt;
    if (!rst_ni) begin
      cmd_if.valid   <= 1'b0;
      cmd_if.command <= CMD_NOP;
      cmd_if.value   <= '0;
      sent_cnt   = 0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready)
        sent_cnt = sent_cnt + 1;
      if (!cmd_if.valid || cmd_if.ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          cmd_if.valid <= 1'b0;
        end else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].hold && sent_cnt != result_cnt)) begin
          nxt = cmd_queue.pop_front();
          cmd_if.valid   <= 1'b1;
          cmd_if.command <= nxt.command;
          cmd_if.value   <= nxt.value;
          burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: switches between always ready, random and mostly stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      mode_left  = 0;
      stall_mode = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left = mode_left - 1;
      end
      case (stall_mode)
        0: begin
          res_if.ready <= 1'b1;
        end
        1: begin
          res_if.ready <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          res_if.ready <= ($urandom_range(0, 15) == 0);
        end
      endcase
    end
  end

  // monitor: check results first, then predict the accepted command
  always @(posedge clk_i) begin
    heap_result_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        result_cnt = result_cnt + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d data=%0d count=%0d", $time,
                   res_if.status, $signed(res_if.data), res_if.item_count);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (res_if.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     res_if.status);
            failed = 1'b1;
          end
          if (res_if.data !== want.data) begin
            $display("%0t: data expected %0d actual %0d", $time, $signed(want.data),
                     $signed(res_if.data));
            failed = 1'b1;
          end
          if (res_if.item_count !== want.item_count) begin
            $display("%0t: item_count expected %0d actual %0d", $time,
                     want.item_count, res_if.item_count);
            failed = 1'b1;
          end
        end
      end
      if (cmd_if.valid && cmd_if.ready)
        expected_results.push_back(heap_predict(cmd_if.command, cmd_if.value));
    end
  end

  task automatic push_cmd(logic [1:0] cmd, logic [DATA_W-1:0] val, bit hold = 1'b0);
    heap_cmd_t item;
    item.command = cmd;
    item.value   = val;
    item.hold    = hold;
    cmd_queue.push_back(item);
    if (cmd == CMD_INSERT && gen_count < CAPACITY)
      gen_count = gen_count + 1;
    else if (cmd == CMD_EXTRACT && gen_count > 0)
      gen_count = gen_count - 1;
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = {1'b0, {(DATA_W-1){1'b1}}};
          1:       v = {1'b1, {(DATA_W-1){1'b0}}};
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3: begin
        // narrow range so equal entries are common
        v = $urandom_range(0, 16) - 8;
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  function automatic logic [1:0] rand_command();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      return CMD_INSERT;
    else if (pick < 80) return CMD_EXTRACT;
    else if (pick < 95) return CMD_PEEK;
    else                return CMD_NOP;
  endfunction

  // stimulus
  initial begin
    failed     = 1'b0;
    heap_len   = 0;
    result_cnt = 0;
    gen_count  = 0;

    // directed: empty heap, extremes, no-op, equal children on the way down
    push_cmd(CMD_PEEK, '0);
    push_cmd(CMD_EXTRACT, '1);
    push_cmd(CMD_NOP, '1);
    push_cmd(CMD_INSERT, {1'b0, {(DATA_W-1){1'b1}}});
    push_cmd(CMD_INSERT, {1'b1, {(DATA_W-1){1'b0}}});
    push_cmd(CMD_INSERT, '0);
    push_cmd(CMD_INSERT, '1);
    push_cmd(CMD_PEEK, '1);
    push_cmd(CMD_NOP, '0);
    repeat (4) push_cmd(CMD_EXTRACT, '0);
    push_cmd(CMD_EXTRACT, '0);
    push_cmd(CMD_INSERT, 9);
    push_cmd(CMD_INSERT, 7);
    push_cmd(CMD_INSERT, 7);
    push_cmd(CMD_INSERT, 1);
    push_cmd(CMD_EXTRACT, '0);
    push_cmd(CMD_EXTRACT, '0);
    push_cmd(CMD_PEEK, '0);
    push_cmd(CMD_EXTRACT, '0);
    push_cmd(CMD_EXTRACT, '0);
    push_cmd(CMD_EXTRACT, '0);

    // random mix
    push_cmd(rand_command(), rand_value(), 1'b1);
    repeat (199)
      push_cmd(rand_command(), rand_value(), $urandom_range(0, 99) == 0);

    // fill to capacity, then inserts on a full heap
    while (gen_count < CAPACITY) begin
      if ($urandom_range(0, 19) == 0)
        push_cmd(CMD_PEEK, rand_value());
      else
        push_cmd(CMD_INSERT, rand_value(), $urandom_range(0, 199) == 0);
    end
    repeat (3) push_cmd(CMD_INSERT, rand_value());
    push_cmd(CMD_PEEK, '0);

    // long drain with deep sift-down
    push_cmd(CMD_EXTRACT, rand_value(), 1'b1);
    repeat (249) begin
      if ($urandom_range(0, 9) == 0)
        push_cmd(CMD_PEEK, rand_value());
      else
        push_cmd(CMD_EXTRACT, rand_value());
    end

    repeat (100)
      push_cmd(rand_command(), rand_value(), $urandom_range(0, 99) == 0);

    @(posedge rst_ni);
    while (cmd_queue.size() != 0 || cmd_if.valid) @(posedge clk_i);
    while (expected_results.size() != 0 || sent_cnt != result_cnt) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (!failed) begin
      $display("PASS binary_max_heap_queue");
    end else begin
      $display("FAIL binary_max_heap_queue");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL binary_max_heap_queue");
    $finish;
  end

endmodule

>>> files.f
rtl/bmhq_pkg.sv
rtl/bmhq_cmd_if.sv
rtl/bmhq_res_if.sv
rtl/bmhq_datapath.sv
rtl/bmhq_ctrl.sv
rtl/binary_max_heap_queue.sv
test/tb_top.sv
